[hw/rtl/kps_pkg.sv]
package kps_pkg;

    localparam int KPS_MAX_ROWS = 4;
    localparam int KPS_MAX_COLS = 4;

    localparam int KPS_ROW_W   = 2;
    localparam int KPS_LINES   = 4;
    localparam int KPS_KEY_W   = 4;
    localparam int KPS_MASK_W  = 16;
    localparam int KPS_TICK_W  = 16;
    localparam int KPS_CNT_W   = 3;
    localparam int KPS_SETTLE_W = 8;
    localparam int KPS_CFG_IDX_W = 3;
    localparam int KPS_CFG_DATA_W = 16;

    typedef enum logic [KPS_CFG_IDX_W-1:0] {
        REG_NUM_ROWS   = 3'd0,
        REG_NUM_COLS   = 3'd1,
        REG_SETTLE     = 3'd2,
        REG_SCAN_GAP   = 3'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_RELEASE = 2'd1,
        EV_SINGLE  = 2'd2,
        EV_MULTI   = 2'd3
    } t_event_kind;

    localparam logic [KPS_CNT_W-1:0]      RST_NUM_ROWS = 3'd4;
    localparam logic [KPS_CNT_W-1:0]      RST_NUM_COLS = 3'd4;
    localparam logic [KPS_SETTLE_W-1:0]   RST_SETTLE   = 8'd7;
    localparam logic [KPS_TICK_W-1:0]     RST_SCAN_GAP = 16'd100;

    function automatic logic [KPS_KEY_W-1:0] key_number(
        input logic [KPS_ROW_W-1:0] row,
        input logic [KPS_ROW_W-1:0] col
    );
        logic [KPS_KEY_W-1:0] k;
        case ({row, col})
            4'h0: k = 4'h1;
            4'h1: k = 4'h2;
            4'h2: k = 4'h3;
            4'h3: k = 4'hA;
            4'h4: k = 4'h4;
            4'h5: k = 4'h5;
            4'h6: k = 4'h6;
            4'h7: k = 4'hB;
            4'h8: k = 4'h7;
            4'h9: k = 4'h8;
            4'hA: k = 4'h9;
            4'hB: k = 4'hC;
            4'hC: k = 4'hF;
            4'hD: k = 4'h0;
            4'hE: k = 4'hE;
            4'hF: k = 4'hD;
            default: k = 4'h0;
        endcase
        return k;
    endfunction

endpackage

[hw/rtl/kps_ifs.sv]
interface kps_in_if;
    import kps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KPS_LINES-1:0] col_lines;
    modport source (output valid, output col_lines, input ready);
    modport sink (input valid, input col_lines, output ready);
endinterface

interface kps_out_if;
    import kps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  row_enable;
    logic [KPS_LINES-1:0]  row_low;
    logic [1:0]            event_kind;
    logic [KPS_KEY_W-1:0]  key_num;
    logic [KPS_MASK_W-1:0] key_mask;
    logic                  lamp_on;
    modport source (output valid, output row_enable, output row_low, output event_kind,
                    output key_num, output key_mask, output lamp_on, input ready);
    modport sink (input valid, input row_enable, input row_low, input event_kind,
                  input key_num, input key_mask, input lamp_on, output ready);
endinterface

interface kps_cfg_if;
    import kps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [KPS_CFG_IDX_W-1:0]  index;
    logic [KPS_CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/matrix_keypad_scanner_core.sv]
// Matrix keypad scanner for a keypad of up to four rows and four columns.
// The input channel carries one request per timing tick: the raw, active-low
// column levels seen under the row drive reported for that same tick.
// Every accepted request yields exactly one result on the output channel:
// row driver enable, the one-hot row pulled low, an event code (none,
// release, single press, multi-key change), the key number, the reported
// key mask and the lamp level.
// The configuration channel writes row count, column count, settle time and
// scan gap and is always ready; the user writes it only while the block is
// idle, which the block does not enforce. A result shows in the cycle after
// its request is taken; a request is taken every cycle unless the receiver
// stalls. The tick update is one logic pass from state to result registers.
// When the receiver stalls, the result register holds its contents and the
// input is held off only while that register is full and not being taken.
// Reset loads the default configuration (4 rows, 4 columns, settle 7,
// gap 100), puts the scanner in its idle gap and clears the reported mask,
// lamp and result valid.
module matrix_keypad_scanner_core
    import kps_pkg::*;
#(
    parameter int MAX_ROWS = KPS_MAX_ROWS,
    parameter int MAX_COLS = KPS_MAX_COLS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kps_in_if.sink    i_in,
    kps_out_if.source o_out,
    kps_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_SAMPLE = 2'd2
    } t_phase;

    logic [KPS_CNT_W-1:0]    r_num_rows;
    logic [KPS_CNT_W-1:0]    r_num_cols;
    logic [KPS_SETTLE_W-1:0] r_settle;
    logic [KPS_TICK_W-1:0]   r_scan_gap;

    t_phase                  r_phase, n_phase;
    logic [KPS_ROW_W-1:0]    r_row, n_row;
    logic [KPS_TICK_W-1:0]   r_tick, n_tick;
    logic [KPS_LINES-1:0]    r_prev, n_prev;
    logic [KPS_MASK_W-1:0]   r_scan_mask, n_scan_mask;
    logic [KPS_KEY_W-1:0]    r_last_key, n_last_key;
    logic [KPS_MASK_W-1:0]   r_rep_mask, n_rep_mask;
    logic                    r_lamp, n_lamp;

    logic                    r_out_valid;
    logic                    r_row_enable, n_row_enable;
    logic [KPS_LINES-1:0]    r_row_low, n_row_low;
    t_event_kind             r_event, n_event;
    logic [KPS_KEY_W-1:0]    r_key_num, n_key_num;

    logic                    in_fire;
    logic [KPS_CNT_W-1:0]    eff_rows;
    logic [KPS_CNT_W-1:0]    eff_cols;
    logic [KPS_TICK_W-1:0]   gap;
    logic [KPS_TICK_W-1:0]   tick_inc;
    logic [KPS_LINES-1:0]    pressed;
    logic                    row_done;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;

    always_comb begin
        eff_rows = (r_num_rows == '0) ? KPS_CNT_W'(1) : r_num_rows;
        if (eff_rows > KPS_CNT_W'(MAX_ROWS)) begin
            eff_rows = KPS_CNT_W'(MAX_ROWS);
        end
        eff_cols = r_num_cols;
        if (eff_cols > KPS_CNT_W'(MAX_COLS)) begin
            eff_cols = KPS_CNT_W'(MAX_COLS);
        end
        gap = (r_scan_gap == '0) ? KPS_TICK_W'(1) : r_scan_gap;
        tick_inc = r_tick + KPS_TICK_W'(1);
        for (int c = 0; c < KPS_LINES; c++) begin
            pressed[c] = !i_in.col_lines[c] && (KPS_CNT_W'(c) < eff_cols);
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_row        = r_row;
        n_tick       = r_tick;
        n_prev       = r_prev;
        n_scan_mask  = r_scan_mask;
        n_last_key   = r_last_key;
        n_rep_mask   = r_rep_mask;
        n_lamp       = r_lamp;
        n_row_enable = 1'b0;
        n_row_low    = '0;
        n_event      = EV_NONE;
        n_key_num    = '0;
        row_done     = 1'b0;

        case (r_phase)
            PH_SETTLE: begin
                n_row_enable = 1'b1;
                n_row_low    = KPS_LINES'(1) << r_row;
                if (r_tick < KPS_TICK_W'(r_settle)) begin
                    n_tick = tick_inc;
                end else begin
                    n_prev  = i_in.col_lines;
                    n_phase = PH_SAMPLE;
                end
            end
            PH_SAMPLE: begin
                n_row_enable = 1'b1;
                n_row_low    = KPS_LINES'(1) << r_row;
                if (i_in.col_lines == r_prev) begin
                    row_done = 1'b1;
                end else begin
                    n_prev = i_in.col_lines;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = tick_inc;
                if (tick_inc >= gap) begin
                    n_phase     = PH_SETTLE;
                    n_row       = '0;
                    n_tick      = '0;
                    n_scan_mask = '0;
                    n_last_key  = '0;
                end
            end
        endcase

        if (row_done) begin
            for (int c = 0; c < KPS_LINES; c++) begin
                if (pressed[c]) begin
                    n_last_key = key_number(r_row, KPS_ROW_W'(c));
                    n_scan_mask[n_last_key] = 1'b1;
                end
            end
            n_tick = '0;
            if (KPS_CNT_W'(r_row) + KPS_CNT_W'(1) >= eff_rows) begin
                n_phase = PH_IDLE;
                n_row   = '0;
                if (n_scan_mask != r_rep_mask) begin
                    if (n_scan_mask == '0) begin
                        n_lamp  = 1'b0;
                        n_event = EV_RELEASE;
                    end else if (r_rep_mask == '0) begin
                        n_lamp  = 1'b1;
                        n_event = (n_scan_mask == (KPS_MASK_W'(1) << n_last_key))
                                  ? EV_SINGLE : EV_MULTI;
                    end else begin
                        n_event = EV_MULTI;
                    end
                    n_rep_mask = n_scan_mask;
                    n_key_num  = n_last_key;
                end
            end else begin
                n_row   = r_row + KPS_ROW_W'(1);
                n_phase = PH_SETTLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= RST_NUM_ROWS;
            r_num_cols  <= RST_NUM_COLS;
            r_settle    <= RST_SETTLE;
            r_scan_gap  <= RST_SCAN_GAP;
            r_phase     <= PH_IDLE;
            r_row       <= '0;
            r_tick      <= '0;
            r_prev      <= '0;
            r_scan_mask <= '0;
            r_last_key  <= '0;
            r_rep_mask  <= '0;
            r_lamp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_NUM_ROWS: r_num_rows <= i_cfg.data[KPS_CNT_W-1:0];
                    REG_NUM_COLS: r_num_cols <= i_cfg.data[KPS_CNT_W-1:0];
                    REG_SETTLE:   r_settle   <= i_cfg.data[KPS_SETTLE_W-1:0];
                    REG_SCAN_GAP: r_scan_gap <= i_cfg.data[KPS_TICK_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_phase      <= n_phase;
                r_row        <= n_row;
                r_tick       <= n_tick;
                r_prev       <= n_prev;
                r_scan_mask  <= n_scan_mask;
                r_last_key   <= n_last_key;
                r_rep_mask   <= n_rep_mask;
                r_lamp       <= n_lamp;
                r_out_valid  <= 1'b1;
                r_row_enable <= n_row_enable;
                r_row_low    <= n_row_low;
                r_event      <= n_event;
                r_key_num    <= n_key_num;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.row_enable = r_row_enable;
    assign o_out.row_low    = r_row_low;
    assign o_out.event_kind = r_event;
    assign o_out.key_num    = r_key_num;
    assign o_out.key_mask   = r_rep_mask;
    assign o_out.lamp_on    = r_lamp;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import kps_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int TICK_TARGET = 1250;
    localparam int MAX_PRINTS = 40;

    // Key number of each switch, four bits per entry, entry index row*4 + column.
    localparam logic [63:0] KEY_MAP = 64'hDE0F_C987_B654_A321;

    typedef enum logic [1:0] {
        PH_GAP    = 2'd0,
        PH_SETTLE = 2'd1,
        PH_SAMPLE = 2'd2,
        PH_SPARE  = 2'd3
    } t_scan_phase;

    typedef struct {
        t_scan_phase       phase;
        logic [1:0]        row;
        logic [15:0]       ticks;
        logic [3:0]        prev;
        logic [15:0]       mask;
        logic [3:0]        last;
        logic [15:0]       shown;
        logic              lamp;
    } t_scan_state;

    typedef struct {
        logic [2:0]  rows;
        logic [2:0]  cols;
        logic [7:0]  settle;
        logic [15:0] gap;
    } t_scan_cfg;

    typedef struct {
        logic        en;
        logic [3:0]  row_low;
        t_event_kind ev;
        logic [3:0]  key;
        logic [15:0] mask;
        logic        lamp;
    } t_scan_res;

    typedef struct {
        logic [3:0]  col;
        int unsigned pause;
    } t_tick_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kps_in_if  tick_if ();
    kps_out_if result_if ();
    kps_cfg_if reg_if ();

    matrix_keypad_scanner_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (result_if),
        .i_cfg   (reg_if)
    );

    t_scan_cfg   cur_cfg;
    t_scan_state gen_st;
    t_scan_state model_st;
    t_tick_req   tick_q[$];
    t_scan_res   expected_results[$];

    int unsigned cycle_cnt = 0;
    int unsigned ticks_queued = 0;
    int unsigned results_checked = 0;
    int unsigned pause_cnt = 0;
    int unsigned stall_cnt = 0;
    int unsigned stall_len = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold = 600;
    int          error_count = 0;
    int          settings_run = 0;
    int          holds_done = 0;
    int          ev_seen[4];
    int          keys_left = 0;
    logic [15:0] held_keys = 16'h0000;
    logic        hold_off;
    logic        no_stall = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic t_scan_state scan_reset_state();
        t_scan_state s;
        s.phase = PH_GAP;
        s.row = 2'd0;
        s.ticks = 16'd0;
        s.prev = 4'd0;
        s.mask = 16'd0;
        s.last = 4'd0;
        s.shown = 16'd0;
        s.lamp = 1'b0;
        return s;
    endfunction

    function automatic t_scan_res scan_tick(inout t_scan_state s, input t_scan_cfg c,
                                            input logic [3:0] col);
        t_scan_res   r;
        logic        done;
        logic [15:0] gap;
        int          nrows;
        int          ncols;
        int          idx;
        logic [3:0]  k;
        r.en = 1'b0;
        r.row_low = 4'd0;
        r.ev = EV_NONE;
        r.key = 4'd0;
        done = 1'b0;
        if (s.phase == PH_SETTLE || s.phase == PH_SAMPLE) begin
            r.en = 1'b1;
            r.row_low = 4'b0001 << s.row;
        end
        case (s.phase)
            PH_SETTLE: begin
                if (s.ticks < {8'd0, c.settle}) begin
                    s.ticks = s.ticks + 16'd1;
                end else begin
                    s.prev = col;
                    s.phase = PH_SAMPLE;
                end
            end
            PH_SAMPLE: begin
                if (col == s.prev) begin
                    done = 1'b1;
                end else begin
                    s.prev = col;
                end
            end
            default: begin
                gap = (c.gap == 16'd0) ? 16'd1 : c.gap;
                s.phase = PH_GAP;
                s.ticks = s.ticks + 16'd1;
                if (s.ticks >= gap) begin
                    s.phase = PH_SETTLE;
                    s.row = 2'd0;
                    s.ticks = 16'd0;
                    s.mask = 16'd0;
                    s.last = 4'd0;
                end
            end
        endcase
        if (done) begin
            nrows = (c.rows == 3'd0) ? 1 : ((c.rows > 3'd4) ? 4 : int'(c.rows));
            ncols = (c.cols > 3'd4) ? 4 : int'(c.cols);
            for (int cc = 0; cc < 4; cc++) begin
                if (cc < ncols && !col[cc]) begin
                    idx = int'(s.row) * 4 + cc;
                    k = KEY_MAP[idx*4 +: 4];
                    s.last = k;
                    s.mask[k] = 1'b1;
                end
            end
            if (int'(s.row) + 1 >= nrows) begin
                if (s.mask != s.shown) begin
                    if (s.mask == 16'd0) begin
                        s.lamp = 1'b0;
                        r.ev = EV_RELEASE;
                    end else if (s.shown == 16'd0) begin
                        s.lamp = 1'b1;
                        r.ev = (s.mask == (16'd1 << s.last)) ? EV_SINGLE : EV_MULTI;
                    end else begin
                        r.ev = EV_MULTI;
                    end
                    s.shown = s.mask;
                    r.key = s.last;
                end
                s.phase = PH_GAP;
                s.ticks = 16'd0;
                s.row = 2'd0;
            end else begin
                s.row = s.row + 2'd1;
                s.ticks = 16'd0;
                s.phase = PH_SETTLE;
            end
        end
        r.mask = s.shown;
        r.lamp = s.lamp;
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_checked, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : tick_driver
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            tick_if.col_lines <= 4'hF;
            pause_cnt <= 0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                expected_results.push_back(scan_tick(model_st, cur_cfg, tick_if.col_lines));
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (tick_q.size() == 0) begin
                    tick_if.valid <= 1'b0;
                end else if (pause_cnt < tick_q[0].pause) begin
                    pause_cnt <= pause_cnt + 1;
                    tick_if.valid <= 1'b0;
                end else begin
                    tick_if.valid <= 1'b1;
                    tick_if.col_lines <= tick_q[0].col;
                    void'(tick_q.pop_front());
                    pause_cnt <= 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        int unsigned wait_n;
        int unsigned len_n;
        t_scan_res   e;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            stall_cnt <= 0;
            stall_len <= 0;
        end else begin
            wait_n = stall_cnt;
            len_n = stall_len;
            if (result_if.valid && result_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_error("result arrived with no request pending");
                end else begin
                    e = expected_results.pop_front();
                    compare_field("row_enable", 16'(result_if.row_enable), 16'(e.en));
                    compare_field("row_low", 16'(result_if.row_low), 16'(e.row_low));
                    compare_field("event_kind", 16'(result_if.event_kind), 16'(e.ev));
                    compare_field("key_num", 16'(result_if.key_num), 16'(e.key));
                    compare_field("key_mask", result_if.key_mask, e.mask);
                    compare_field("lamp_on", 16'(result_if.lamp_on), 16'(e.lamp));
                    ev_seen[e.ev]++;
                    results_checked++;
                end
                wait_n = 0;
                len_n = no_stall ? 0 : $urandom_range(0, 10);
            end else if (result_if.valid && wait_n < len_n) begin
                wait_n++;
            end
            stall_cnt <= wait_n;
            stall_len <= len_n;
            result_if.ready <= !hold_off && wait_n >= len_n;
        end
    end

    // A long receiver stall while requests keep coming fills the block and backs up its input.
    always @(posedge i_clk) begin : hold_control
        if (!i_rst_n) begin
            hold_off <= 1'b0;
            hold_left <= 0;
        end else if (hold_off) begin
            if (hold_left == 0) begin
                hold_off <= 1'b0;
            end else begin
                hold_left <= hold_left - 1;
            end
        end else if (cycle_cnt >= next_hold && tick_if.valid) begin
            hold_off <= 1'b1;
            hold_left <= $urandom_range(40, 80);
            next_hold <= cycle_cnt + 2500;
            holds_done <= holds_done + 1;
        end
    end

    task automatic write_reg(input t_reg_index idx, input logic [15:0] val);
        @(posedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data <= val;
        do @(posedge i_clk); while (!(reg_if.valid && reg_if.ready));
        reg_if.valid <= 1'b0;
    endtask

    task automatic apply_cfg(input t_scan_cfg c);
        write_reg(REG_NUM_ROWS, {13'($urandom), c.rows});
        write_reg(REG_NUM_COLS, {13'($urandom), c.cols});
        write_reg(REG_SETTLE, {8'($urandom), c.settle});
        write_reg(REG_SCAN_GAP, c.gap);
        cur_cfg = c;
        settings_run++;
    endtask

    task automatic wait_drained();
        while (results_checked != ticks_queued) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic push_tick(input logic [15:0] keys, input bit bounce);
        t_tick_req t;
        t_scan_res unused;
        if ((gen_st.phase == PH_SETTLE || gen_st.phase == PH_SAMPLE) && !bounce) begin
            t.col = ~keys[gen_st.row*4 +: 4];
        end else begin
            t.col = 4'($urandom_range(0, 15));
        end
        unused = scan_tick(gen_st, cur_cfg, t.col);
        t.pause = no_stall ? 0 : $urandom_range(0, 10);
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    task automatic run_phase(input t_scan_cfg c, input int count);
        int span;
        int pick;
        wait_drained();
        apply_cfg(c);
        no_stall = ($urandom_range(0, 3) == 0);
        span = ((c.gap == 16'd0) ? 1 : int'(c.gap)) + 4 * (int'(c.settle) + 3);
        repeat (count) begin
            if (keys_left <= 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    held_keys = 16'h0000;
                end else if (pick < 60) begin
                    held_keys = 16'd1 << $urandom_range(0, 15);
                end else if (pick < 95) begin
                    held_keys = 16'($urandom & $urandom);
                end else begin
                    held_keys = 16'hFFFF;
                end
                keys_left = $urandom_range(1, 3 * span);
            end
            keys_left--;
            push_tick(held_keys, $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_scan_cfg c;
        int        pick;
        i_rst_n = 1'b0;
        reg_if.valid = 1'b0;
        reg_if.index = REG_NUM_ROWS;
        reg_if.data = 16'd0;
        cur_cfg = '{RST_NUM_ROWS, RST_NUM_COLS, RST_SETTLE, RST_SCAN_GAP};
        gen_st = scan_reset_state();
        model_st = scan_reset_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every key at once, then all released, then the single key numbered zero.
        apply_cfg('{3'd4, 3'd4, 8'd0, 16'd1});
        repeat (9) push_tick(16'hFFFF, 1'b0);
        repeat (9) push_tick(16'h0000, 1'b0);
        repeat (9) push_tick(16'h2000, 1'b0);

        run_phase('{3'd0, 3'd0, 8'd0, 16'd0}, 40);
        run_phase('{3'd7, 3'd7, 8'd1, 16'd1}, 60);
        run_phase('{3'd1, 3'd4, 8'd255, 16'd2}, 280);
        run_phase('{3'd4, 3'd1, 8'd3, 16'd65535}, 20);

        while (ticks_queued < TICK_TARGET) begin
            c.rows = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
            c.cols = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
            pick = $urandom_range(0, 19);
            c.settle = (pick < 14) ? 8'($urandom_range(0, 3))
                     : (pick < 19) ? 8'($urandom_range(4, 20))
                     : 8'($urandom_range(21, 40));
            pick = $urandom_range(0, 19);
            c.gap = (pick < 12) ? 16'($urandom_range(1, 6))
                  : (pick < 15) ? 16'd0
                  : (pick < 19) ? 16'($urandom_range(7, 40))
                  : 16'($urandom_range(100, 300));
            run_phase(c, $urandom_range(60, 150));
        end

        wait_drained();
        if (expected_results.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
        end
        $display("Scanned %0d ticks under %0d register settings, %0d long receiver stalls.",
                 ticks_queued, settings_run, holds_done);
        $display("Events: %0d releases, %0d single presses, %0d multi-key changes, %0d errors.",
                 ev_seen[EV_RELEASE], ev_seen[EV_SINGLE], ev_seen[EV_MULTI], error_count);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
